// File: design/bitmap_first_free_allocator_macros.svh
// ----------------------------------------------------------------------------
// Bitmap first-free allocator assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BFFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Commands, sequencer states and result type of the bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

	localparam logic [1:0] CMD_ALLOC_INODE = 2'd0;
	localparam logic [1:0] CMD_ALLOC_DATA  = 2'd1;
	localparam logic [1:0] CMD_LOAD_INODE  = 2'd2;
	localparam logic [1:0] CMD_LOAD_DATA   = 2'd3;

	localparam logic [15:0] REGION_START_RST = 16'd131;
	localparam logic [7:0]  BYTE_USED        = 8'hFF;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [12:0] allocated_index;
		logic [16:0] block_address;
		logic        map_full;
	} result_t;

endpackage

`default_nettype wire

// File: design/bitmap_first_free_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// Inode and data-block bitmaps with first-fit allocation and byte loads.
// ----------------------------------------------------------------------------
//  channel | signals                                   | request
//  in      | in_valid/in_ready, command, byte_index,   | one command
//          | byte_value                                |
//  out     | out_valid/out_ready, allocated_index,     | one result per allocate
//          | block_address, map_full                   |
//  cfg     | cfg_we, cfg_wdata                         | data region start write
//
// A load returns nothing. An allocate scans the chosen map one byte per cycle
// from the lowest byte that may be free; when the map is already known to be
// full, the result is given without a scan.
// After reset both maps are zeroed one byte per cycle, and in_ready stays low
// until that clearing pass ends. A result waits in the output register; a new
// command is taken meanwhile, and its result waits until that register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_free_allocator #(
	parameter int MAP_BYTES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [9:0]  byte_index,
	input  wire logic [7:0]  byte_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [12:0]      allocated_index,
	output logic [16:0]      block_address,
	output logic             map_full,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	logic [15:0]       region_start_q;
	logic              res_valid, res_ready;
	bffa_pkg::result_t res;
	logic              out_valid_q;
	bffa_pkg::result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= bffa_pkg::REGION_START_RST;
		end else if (cfg_we) begin
			region_start_q <= cfg_wdata;
		end
	end

	bffa_ctrl #(.MAP_BYTES(MAP_BYTES)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.byte_index   (byte_index),
		.byte_value   (byte_value),
		.region_start (region_start_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign allocated_index = out_q.allocated_index;
	assign block_address   = out_q.block_address;
	assign map_full        = out_q.map_full;

endmodule

`default_nettype wire

// File: design/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [ADDR_W-1:0]       wr_addr,
	input  wire logic [WIDTH-1:0]        wr_data,
	input  wire logic                    rd_en,
	input  wire logic [ADDR_W-1:0]       rd_addr,
	output logic      [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Map memories, clearing pass, byte scan and read-modify-write of a claim.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_ctrl #(
	parameter int MAP_BYTES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        command,
	input  wire logic [9:0]        byte_index,
	input  wire logic [7:0]        byte_value,
	input  wire logic [15:0]       region_start,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output bffa_pkg::result_t      res
);

	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CW = $clog2(MAP_BYTES + 1);
	localparam int IW = AW + 3;
	localparam logic [CW-1:0] MAP_END  = CW'(MAP_BYTES);
	localparam logic [AW-1:0] LAST_ROW = AW'(MAP_BYTES - 1);

	bffa_pkg::state_t state_q, state_d;

	logic [AW-1:0] clr_addr_q;
	logic [CW-1:0] scan_addr_q;
	logic          map_sel_q;      // 1: data map
	logic          rvalid_s1;
	logic [AW-1:0] raddr_s1;
	logic [CW-1:0] hint_inode_q;   // every byte below the hint is full
	logic [CW-1:0] hint_data_q;
	bffa_pkg::result_t res_q;

	logic          accept, is_load, load_ok, alloc_go, alloc_data;
	logic [CW-1:0] start_hint;
	logic          start_full;
	logic [7:0]    inode_rd, data_rd, rd_byte, new_byte;
	logic          found, exhausted, issue;
	logic [2:0]    bit_sel;
	logic [IW-1:0] found_idx;
	logic [16:0]   found_addr;
	logic [CW-1:0] next_hint;

	logic          inode_we, data_we;
	logic [AW-1:0] inode_wa, data_wa;
	logic [7:0]    inode_wd, data_wd;

	assign in_ready  = (state_q == bffa_pkg::ST_IDLE);
	assign res_valid = (state_q == bffa_pkg::ST_DONE);
	assign res       = res_q;

	assign accept     = in_valid && in_ready;
	assign is_load    = (command == bffa_pkg::CMD_LOAD_INODE) ||
	                    (command == bffa_pkg::CMD_LOAD_DATA);
	assign load_ok    = accept && is_load && (32'(byte_index) < MAP_BYTES);
	assign alloc_go   = accept && !is_load;
	assign alloc_data = (command == bffa_pkg::CMD_ALLOC_DATA);
	assign start_hint = alloc_data ? hint_data_q : hint_inode_q;
	assign start_full = (start_hint == MAP_END);

	assign rd_byte   = map_sel_q ? data_rd : inode_rd;
	assign found     = (state_q == bffa_pkg::ST_SCAN) && rvalid_s1 &&
	                   (rd_byte != bffa_pkg::BYTE_USED);
	assign exhausted = (state_q == bffa_pkg::ST_SCAN) && rvalid_s1 &&
	                   (rd_byte == bffa_pkg::BYTE_USED) && (raddr_s1 == LAST_ROW);
	assign issue     = (state_q == bffa_pkg::ST_SCAN) && !found && !exhausted &&
	                   (scan_addr_q < MAP_END);

	// lowest clear bit of the byte coming back
	always_comb begin
		bit_sel = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (!rd_byte[b]) begin
				bit_sel = 3'(b);
			end
		end
	end

	assign new_byte   = rd_byte | (8'h01 << bit_sel);
	assign found_idx  = {raddr_s1, bit_sel};
	assign found_addr = 17'(found_idx) + (map_sel_q ? 17'(region_start) : 17'd0);
	assign next_hint  = (new_byte == bffa_pkg::BYTE_USED) ? (CW'(raddr_s1) + CW'(1)) :
	                    CW'(raddr_s1);

	// write port: clearing pass, then claim write-back, then loads
	always_comb begin
		inode_we = 1'b0;
		inode_wa = AW'(byte_index);
		inode_wd = byte_value;
		data_we  = 1'b0;
		data_wa  = AW'(byte_index);
		data_wd  = byte_value;
		if (state_q == bffa_pkg::ST_CLEAR) begin
			inode_we = 1'b1;
			inode_wa = clr_addr_q;
			inode_wd = 8'h00;
			data_we  = 1'b1;
			data_wa  = clr_addr_q;
			data_wd  = 8'h00;
		end else if (found) begin
			inode_we = !map_sel_q;
			inode_wa = raddr_s1;
			inode_wd = new_byte;
			data_we  = map_sel_q;
			data_wa  = raddr_s1;
			data_wd  = new_byte;
		end else begin
			inode_we = load_ok && (command == bffa_pkg::CMD_LOAD_INODE);
			data_we  = load_ok && (command == bffa_pkg::CMD_LOAD_DATA);
		end
	end

	bffa_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_inode_ram (
		.clk     (clk),
		.wr_en   (inode_we),
		.wr_addr (inode_wa),
		.wr_data (inode_wd),
		.rd_en   (issue),
		.rd_addr (scan_addr_q[AW-1:0]),
		.rd_data (inode_rd)
	);

	bffa_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_data_ram (
		.clk     (clk),
		.wr_en   (data_we),
		.wr_addr (data_wa),
		.wr_data (data_wd),
		.rd_en   (issue),
		.rd_addr (scan_addr_q[AW-1:0]),
		.rd_data (data_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bffa_pkg::ST_CLEAR: begin
				if (clr_addr_q == LAST_ROW) begin
					state_d = bffa_pkg::ST_IDLE;
				end
			end
			bffa_pkg::ST_IDLE: begin
				if (alloc_go) begin
					state_d = start_full ? bffa_pkg::ST_DONE : bffa_pkg::ST_SCAN;
				end
			end
			bffa_pkg::ST_SCAN: begin
				if (found || exhausted) begin
					state_d = bffa_pkg::ST_DONE;
				end
			end
			bffa_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = bffa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bffa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bffa_pkg::ST_CLEAR;
			clr_addr_q   <= '0;
			rvalid_s1    <= 1'b0;
			hint_inode_q <= '0;
			hint_data_q  <= '0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= issue;
			if (state_q == bffa_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (found) begin
				if (map_sel_q) begin
					hint_data_q <= next_hint;
				end else begin
					hint_inode_q <= next_hint;
				end
			end else if (exhausted) begin
				if (map_sel_q) begin
					hint_data_q <= MAP_END;
				end else begin
					hint_inode_q <= MAP_END;
				end
			end else if (load_ok) begin
				// a load below the hint may free a byte there
				if (command == bffa_pkg::CMD_LOAD_DATA) begin
					if (32'(byte_index) < 32'(hint_data_q)) begin
						hint_data_q <= CW'(byte_index);
					end
				end else begin
					if (32'(byte_index) < 32'(hint_inode_q)) begin
						hint_inode_q <= CW'(byte_index);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_go) begin
			scan_addr_q <= start_hint;
			map_sel_q   <= alloc_data;
		end else if (issue) begin
			scan_addr_q <= scan_addr_q + CW'(1);
		end
		if (issue) begin
			raddr_s1 <= scan_addr_q[AW-1:0];
		end
		if ((alloc_go && start_full) || exhausted) begin
			res_q.allocated_index <= 13'd0;
			res_q.block_address   <= 17'd0;
			res_q.map_full        <= 1'b1;
		end else if (found) begin
			res_q.allocated_index <= 13'(found_idx);
			res_q.block_address   <= found_addr;
			res_q.map_full        <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: design/bffa_checker.sv
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_first_free_allocator_macros.svh"

module bffa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  command,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [12:0] allocated_index,
	input wire logic [16:0] block_address,
	input wire logic        map_full
);

	logic alloc_req, load_req;

	assign alloc_req = in_valid && in_ready &&
	                   ((command == bffa_pkg::CMD_ALLOC_INODE) ||
	                    (command == bffa_pkg::CMD_ALLOC_DATA));
	assign load_req  = in_valid && in_ready &&
	                   ((command == bffa_pkg::CMD_LOAD_INODE) ||
	                    (command == bffa_pkg::CMD_LOAD_DATA));

	// a stalled result holds
	`BFFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(allocated_index) && $stable(block_address) && $stable(map_full), "stalled result changed")

	// a full map reports nothing else
	`BFFA_ASSERT_NOW(a_full_zero, out_valid && map_full, (allocated_index == 13'd0) && (block_address == 17'd0), "full result carries an index")

	// an allocate request occupies the block while it scans
	`BFFA_ASSERT_NEXT(a_alloc_busy, alloc_req, !in_ready, "request taken during an allocate")

	// a load creates no result
	`BFFA_ASSERT_NEXT(a_load_silent, load_req && !out_valid, !out_valid, "load produced a result")

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap first-free allocator. Commands go in on
// the input channel; a shadow copy of both bitmaps predicts each allocation,
// and every result leaving the block is checked against the oldest prediction.
// Covers directed cases, region start extremes, random mixed traffic with
// mount-style load bursts and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAP_BYTES   = 1024;
	localparam int STUCK_LIMIT = 12000;
	localparam int MAP_INODE   = 0;
	localparam int MAP_DATA    = 1;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [1:0]  command    = bffa_pkg::CMD_ALLOC_INODE;
	logic [9:0]  byte_index = '0;
	logic [7:0]  byte_value = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [12:0] allocated_index;
	logic [16:0] block_address;
	logic        map_full;
	logic        cfg_we     = 1'b0;
	logic [15:0] cfg_wdata  = '0;

	// shadow bitmaps, [0] inode, [1] data
	logic [7:0]  bitmap_copy [2][MAP_BYTES];
	logic [15:0] region_start = bffa_pkg::REGION_START_RST;
	bffa_pkg::result_t pending_allocs [$];

	int mismatches   = 0;
	int stuck_cycles = 0;
	int hold_req     = 0;
	int rx_wait      = 0;
	bit idle_on      = 1'b0;

	bitmap_first_free_allocator #(
		.MAP_BYTES(MAP_BYTES)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.byte_index     (byte_index),
		.byte_value     (byte_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.allocated_index(allocated_index),
		.block_address  (block_address),
		.map_full       (map_full),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	always #4 clk = ~clk;

	initial begin
		for (int m = 0; m < 2; m++)
			for (int i = 0; i < MAP_BYTES; i++)
				bitmap_copy[m][i] = 8'h00;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// first-fit claim on the shadow maps, or a byte load
	task automatic apply_command(input logic [1:0] cmd, input logic [9:0] idx,
			input logic [7:0] val);
		int                m;
		int                found;
		int                sum;
		bffa_pkg::result_t r;
		m = (cmd == bffa_pkg::CMD_ALLOC_DATA || cmd == bffa_pkg::CMD_LOAD_DATA) ?
			MAP_DATA : MAP_INODE;
		if (cmd == bffa_pkg::CMD_LOAD_INODE || cmd == bffa_pkg::CMD_LOAD_DATA) begin
			if (idx < MAP_BYTES)
				bitmap_copy[m][idx] = val;
		end else begin
			found = -1;
			for (int i = 0; i < MAP_BYTES && found < 0; i++)
				if (bitmap_copy[m][i] != bffa_pkg::BYTE_USED)
					for (int b = 0; b < 8 && found < 0; b++)
						if (!bitmap_copy[m][i][b]) begin
							bitmap_copy[m][i][b] = 1'b1;
							found = i * 8 + b;
						end
			if (found < 0) begin
				r.allocated_index = '0;
				r.block_address   = '0;
				r.map_full        = 1'b1;
			end else begin
				sum = found + ((m == MAP_DATA) ? int'(region_start) : 0);
				r.allocated_index = found[12:0];
				r.block_address   = sum[16:0];
				r.map_full        = 1'b0;
			end
			pending_allocs.push_back(r);
		end
	endtask

	task automatic send_cmd(input logic [1:0] cmd, input logic [9:0] idx,
			input logic [7:0] val);
		int gap;
		gap = idle_on ? gap_len() : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command    <= cmd;
		byte_index <= idx;
		byte_value <= val;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_command(cmd, idx, val);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_allocs.size() != 0)
			@(posedge clk);
		// a load may still be in flight
		repeat (16) @(posedge clk);
	endtask

	task automatic set_region_start(input logic [15:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		region_start = v;
	endtask

	task automatic test_directed_cmds();
		idle_on = 1'b0;
		send_cmd(bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_LOAD_INODE, 10'd0, bffa_pkg::BYTE_USED);
		send_cmd(bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_LOAD_DATA, 10'd0, 8'h7F);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_LOAD_INODE, 10'd1023, 8'hAA);
		send_cmd(bffa_pkg::CMD_LOAD_DATA, 10'd1023, 8'h55);
		send_cmd(bffa_pkg::CMD_LOAD_INODE, 10'h2AA, 8'h55);
		send_cmd(bffa_pkg::CMD_LOAD_DATA, 10'h155, 8'hAA);
		idle_on = 1'b1;
		send_cmd(bffa_pkg::CMD_LOAD_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_LOAD_INODE, 10'd0, bffa_pkg::BYTE_USED);
		send_cmd(bffa_pkg::CMD_LOAD_INODE, 10'd1, 8'hEF);
		send_cmd(bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_LOAD_DATA, 10'd1, bffa_pkg::BYTE_USED);
		send_cmd(bffa_pkg::CMD_LOAD_DATA, 10'd2, 8'h80);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
	endtask

	task automatic test_region_start_extremes();
		idle_on = 1'b1;
		set_region_start(16'd0);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		set_region_start(16'hFFFF);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
	endtask

	task automatic test_random_traffic(input int n, input logic [15:0] start,
			input bit idle);
		int         sent;
		int         r;
		int         burst;
		logic [1:0] cmd;
		logic [9:0] idx;
		logic [7:0] val;
		set_region_start(start);
		idle_on = idle;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				// mount-like run of used bytes from the bottom of one map
				cmd   = $urandom_range(0, 1) ? bffa_pkg::CMD_LOAD_DATA :
					bffa_pkg::CMD_LOAD_INODE;
				burst = $urandom_range(1, 24);
				for (int j = 0; j < burst; j++)
					send_cmd(cmd, j[9:0], bffa_pkg::BYTE_USED);
				sent += burst;
				continue;
			end
			if (r < 30)
				cmd = bffa_pkg::CMD_ALLOC_INODE;
			else if (r < 56)
				cmd = bffa_pkg::CMD_ALLOC_DATA;
			else if (r < 78)
				cmd = bffa_pkg::CMD_LOAD_INODE;
			else
				cmd = bffa_pkg::CMD_LOAD_DATA;
			r = $urandom_range(0, 99);
			if (r < 70)
				idx = 10'($urandom_range(0, 31));
			else
				idx = 10'($urandom_range(0, MAP_BYTES - 1));
			r = $urandom_range(0, 99);
			if (r < 30)
				val = 8'h00;
			else if (r < 50)
				val = bffa_pkg::BYTE_USED;
			else
				val = 8'($urandom_range(0, 255));
			send_cmd(cmd, idx, val);
			sent++;
		end
	endtask

	task automatic test_backpressure();
		idle_on = 1'b1;
		wait_drained();
		hold_req = 400;
		for (int i = 0; i < 12; i++)
			send_cmd($urandom_range(0, 1) ? bffa_pkg::CMD_ALLOC_DATA :
				bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_LOAD_DATA, 10'd3, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
		// sender stops until every result is back
		wait_drained();
		send_cmd(bffa_pkg::CMD_ALLOC_INODE, 10'd0, 8'h00);
		send_cmd(bffa_pkg::CMD_ALLOC_DATA, 10'd0, 8'h00);
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != 0) begin
			rx_wait  = hold_req;
			hold_req = 0;
		end
		if (rx_wait != 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			rx_wait = gap_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		bffa_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_allocs.size() == 0) begin
				flag_error($sformatf("result with no request pending: index %0d",
					allocated_index));
			end else begin
				want = pending_allocs.pop_front();
				if (allocated_index !== want.allocated_index)
					flag_error($sformatf("allocated_index got %0d expected %0d",
						allocated_index, want.allocated_index));
				if (block_address !== want.block_address)
					flag_error($sformatf("block_address got %0d expected %0d",
						block_address, want.block_address));
				if (map_full !== want.map_full)
					flag_error($sformatf("map_full got %0b expected %0b",
						map_full, want.map_full));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", STUCK_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cmds();
		test_region_start_extremes();
		test_random_traffic(135, 16'($urandom_range(0, 65535)), 1'b1);
		test_random_traffic(135, 16'd0, 1'b0);
		test_random_traffic(135, 16'hFFFF, 1'b1);
		test_backpressure();
		test_random_traffic(135, bffa_pkg::REGION_START_RST, 1'b1);
		wait_drained();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && pending_allocs.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/bffa_pkg.sv
design/bffa_ram.sv
design/bffa_ctrl.sv
design/bitmap_first_free_allocator.sv
design/bffa_checker.sv
test/tb_top.sv
